[hdl/iebam_pkg.sv]
package iebam_pkg;

    // Transfer phase codes of the bus sequencer.
    localparam int PHASE_W = 5;

    localparam logic [PHASE_W-1:0] PH_IDLE = 5'd0;
    localparam logic [PHASE_W-1:0] PH_ST_A = 5'd1;
    localparam logic [PHASE_W-1:0] PH_ST_B = 5'd2;
    localparam logic [PHASE_W-1:0] PH_TX_C = 5'd3;
    localparam logic [PHASE_W-1:0] PH_AK_C = 5'd4;
    localparam logic [PHASE_W-1:0] PH_TX_A = 5'd5;
    localparam logic [PHASE_W-1:0] PH_AK_A = 5'd6;
    localparam logic [PHASE_W-1:0] PH_TX_D = 5'd7;
    localparam logic [PHASE_W-1:0] PH_AK_D = 5'd8;
    localparam logic [PHASE_W-1:0] PH_RS_A = 5'd9;
    localparam logic [PHASE_W-1:0] PH_RS_B = 5'd10;
    localparam logic [PHASE_W-1:0] PH_RS_C = 5'd11;
    localparam logic [PHASE_W-1:0] PH_TX_R = 5'd12;
    localparam logic [PHASE_W-1:0] PH_AK_R = 5'd13;
    localparam logic [PHASE_W-1:0] PH_RX   = 5'd14;
    localparam logic [PHASE_W-1:0] PH_NACK = 5'd15;
    localparam logic [PHASE_W-1:0] PH_SP_A = 5'd16;
    localparam logic [PHASE_W-1:0] PH_SP_B = 5'd17;
    localparam logic [PHASE_W-1:0] PH_SP_C = 5'd18;
    localparam logic [PHASE_W-1:0] PH_WCYC = 5'd19;

    // Configuration register indexes.
    localparam logic REG_ACK_WAIT_LIMIT    = 1'b0;
    localparam logic REG_WRITE_CYCLE_TICKS = 1'b1;

    localparam logic [7:0]  ACK_WAIT_LIMIT_RST    = 8'd200;
    localparam logic [15:0] WRITE_CYCLE_TICKS_RST = 16'd5000;

    // Fixed upper bits of the EEPROM control byte.
    localparam logic [7:0] CTRL_BYTE_BASE = 8'hA0;
    localparam logic [3:0] LAST_HALF_BIT  = 4'd15;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    // One timing tick as it enters the sequencer.
    typedef struct packed {
        logic       cmd_valid;
        logic       func;
        logic [7:0] word_addr;
        logic [2:0] page_sel;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    // Line levels and status produced for one tick.
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       chip_select_n;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_data;
        logic       ack_missing;
    } result_t;

    // Current setting of the configuration registers.
    typedef struct packed {
        logic [7:0]  ack_wait_limit;
        logic [15:0] write_cycle_ticks;
    } cfg_t;

    function automatic logic [7:0] control_byte(input logic [2:0] page);
        control_byte = CTRL_BYTE_BASE | {4'd0, page, 1'b0};
    endfunction

endpackage

[hdl/iebam_core.sv]
// Bus sequencer: holds the transfer state and advances it by one tick on each step.
module iebam_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  iebam_pkg::item_t  item,
    input  iebam_pkg::cfg_t   cfg,
    output iebam_pkg::result_t result
);

    logic [iebam_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] wait_count_reg, wait_count_next;
    logic [7:0]  addr_reg, addr_next;
    logic [2:0]  page_reg, page_next;
    logic [7:0]  data_reg, data_next;
    logic        is_read_reg, is_read_next;
    logic        nack_reg, nack_next;

    logic       scl, sda, busy, rv, active;
    logic [7:0] rd;
    logic       ack_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= iebam_pkg::PH_IDLE;
            bit_count_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            wait_count_reg <= 16'd0;
            addr_reg       <= 8'd0;
            page_reg       <= 3'd0;
            data_reg       <= 8'd0;
            is_read_reg    <= 1'b0;
            nack_reg       <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            wait_count_reg <= wait_count_next;
            addr_reg       <= addr_next;
            page_reg       <= page_next;
            data_reg       <= data_next;
            is_read_reg    <= is_read_next;
            nack_reg       <= nack_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        wait_count_next = wait_count_reg;
        addr_next       = addr_reg;
        page_next       = page_reg;
        data_next       = data_reg;
        is_read_next    = is_read_reg;
        nack_next       = nack_reg;
        scl      = 1'b1;
        sda      = 1'b1;
        busy     = 1'b1;
        rv       = 1'b0;
        rd       = 8'd0;
        active   = (phase_reg != iebam_pkg::PH_IDLE);
        ack_done = 1'b0;

        unique case (phase_reg)
            iebam_pkg::PH_IDLE:
            begin
                busy = 1'b0;
                if (item.cmd_valid)
                begin
                    addr_next       = item.word_addr;
                    page_next       = item.page_sel;
                    data_next       = item.write_data;
                    is_read_next    = item.func;
                    nack_next       = 1'b0;
                    bit_count_next  = 4'd0;
                    wait_count_next = 16'd0;
                    shift_next      = iebam_pkg::control_byte(item.page_sel);
                    phase_next      = iebam_pkg::PH_ST_A;
                    busy            = 1'b1;
                    active          = 1'b1;
                end
            end
            iebam_pkg::PH_ST_A: phase_next = iebam_pkg::PH_ST_B;
            iebam_pkg::PH_ST_B:
            begin
                sda            = 1'b0;
                phase_next     = iebam_pkg::PH_TX_C;
                bit_count_next = 4'd0;
            end
            iebam_pkg::PH_TX_C, iebam_pkg::PH_TX_A, iebam_pkg::PH_TX_D,
            iebam_pkg::PH_TX_R:
            begin
                // Each bit takes two ticks: SCL low with data set up, then SCL high.
                sda = shift_reg[7];
                scl = bit_count_reg[0];
                if (bit_count_reg[0])
                    shift_next = {shift_reg[6:0], 1'b0};
                if (bit_count_reg == iebam_pkg::LAST_HALF_BIT)
                begin
                    // Every transmit phase code is followed by its acknowledge code.
                    phase_next      = phase_reg + 5'd1;
                    bit_count_next  = 4'd0;
                    wait_count_next = 16'd0;
                end
                else
                    bit_count_next = bit_count_reg + 4'd1;
            end
            iebam_pkg::PH_AK_C, iebam_pkg::PH_AK_A, iebam_pkg::PH_AK_D,
            iebam_pkg::PH_AK_R:
            begin
                sda = 1'b1;
                if (bit_count_reg == 4'd0)
                begin
                    scl = 1'b1;
                    if (!item.sda_in)
                        bit_count_next = 4'd1;
                    else if (wait_count_reg >= {8'd0, cfg.ack_wait_limit})
                    begin
                        nack_next      = 1'b1;
                        bit_count_next = 4'd1;
                    end
                    else
                        wait_count_next = wait_count_reg + 16'd1;
                end
                else
                begin
                    scl            = 1'b0;
                    bit_count_next = 4'd0;
                    ack_done       = 1'b1;
                end
                if (ack_done)
                begin
                    unique case (phase_reg)
                        iebam_pkg::PH_AK_C:
                        begin
                            shift_next = addr_reg;
                            phase_next = iebam_pkg::PH_TX_A;
                        end
                        iebam_pkg::PH_AK_A:
                        begin
                            if (is_read_reg)
                                phase_next = iebam_pkg::PH_RS_A;
                            else
                            begin
                                shift_next = data_reg;
                                phase_next = iebam_pkg::PH_TX_D;
                            end
                        end
                        iebam_pkg::PH_AK_D: phase_next = iebam_pkg::PH_SP_A;
                        default:
                        begin
                            shift_next = 8'd0;
                            phase_next = iebam_pkg::PH_RX;
                        end
                    endcase
                end
            end
            iebam_pkg::PH_RS_A:
            begin
                scl        = 1'b0;
                phase_next = iebam_pkg::PH_RS_B;
            end
            iebam_pkg::PH_RS_B: phase_next = iebam_pkg::PH_RS_C;
            iebam_pkg::PH_RS_C:
            begin
                sda            = 1'b0;
                shift_next     = iebam_pkg::control_byte(page_reg) | 8'd1;
                bit_count_next = 4'd0;
                phase_next     = iebam_pkg::PH_TX_R;
            end
            iebam_pkg::PH_RX:
            begin
                scl = bit_count_reg[0];
                if (bit_count_reg[0])
                    shift_next = {shift_reg[6:0], item.sda_in};
                if (bit_count_reg == iebam_pkg::LAST_HALF_BIT)
                begin
                    bit_count_next = 4'd0;
                    phase_next     = iebam_pkg::PH_NACK;
                end
                else
                    bit_count_next = bit_count_reg + 4'd1;
            end
            iebam_pkg::PH_NACK:
            begin
                scl = bit_count_reg[0];
                if (bit_count_reg == 4'd0)
                    bit_count_next = 4'd1;
                else
                begin
                    bit_count_next = 4'd0;
                    phase_next     = iebam_pkg::PH_SP_A;
                end
            end
            iebam_pkg::PH_SP_A:
            begin
                scl        = 1'b0;
                sda        = 1'b0;
                phase_next = iebam_pkg::PH_SP_B;
            end
            iebam_pkg::PH_SP_B:
            begin
                sda        = 1'b0;
                phase_next = iebam_pkg::PH_SP_C;
            end
            iebam_pkg::PH_SP_C:
            begin
                if (is_read_reg)
                begin
                    rv         = 1'b1;
                    rd         = shift_reg;
                    phase_next = iebam_pkg::PH_IDLE;
                end
                else
                begin
                    wait_count_next = 16'd0;
                    phase_next      = iebam_pkg::PH_WCYC;
                end
            end
            iebam_pkg::PH_WCYC:
            begin
                if (wait_count_reg >= cfg.write_cycle_ticks)
                    phase_next = iebam_pkg::PH_IDLE;
                else
                    wait_count_next = wait_count_reg + 16'd1;
            end
            default:
            begin
                busy       = 1'b0;
                active     = 1'b0;
                phase_next = iebam_pkg::PH_IDLE;
            end
        endcase

        result.scl_out       = scl;
        result.sda_out       = sda;
        result.chip_select_n = !(active && !is_read_next);
        result.busy_res      = busy;
        result.read_valid    = rv;
        result.read_data     = rd;
        result.ack_missing   = nack_next;
    end

endmodule

[hdl/iebam_outbuf.sv]
// Output register with skid slot; the input side stops only while the skid is full.
module iebam_outbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  iebam_pkg::result_t  push_data,
    output logic                push_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output iebam_pkg::result_t  out_data
);

    logic               out_valid_reg;
    logic               skid_valid_reg;
    iebam_pkg::result_t out_data_reg;
    iebam_pkg::result_t skid_data_reg;
    logic               load;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign load       = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        else if (push)
            skid_data_reg <= push_data;
    end

endmodule

[hdl/i2c_eeprom_byte_access_master.sv]
// Path: a tick is held in the input register, the sequencer computes its result from
// it, and the result is captured in the output register that drives m_tvalid.
// Throughput: one tick per clock while the output skid slot is empty; the sequencer
// steps once per tick, with the single state update between the two registers.
// Reset (rst_n low, asynchronous): bus idle, all pipeline slots empty, configuration
// back to an acknowledge wait of 200 ticks and a write cycle wait of 5000 ticks.
module i2c_eeprom_byte_access_master (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_data,
    // Tick input. tuser: cmd_valid, func.
    // tdata: word_addr[7:0], page_sel[10:8], write_data[18:11], sda_in[19], zero pad.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,
    input  logic [iebam_pkg::IN_TDATA_W-1:0] s_tdata,
    // Result output. tuser: read_valid.
    // tdata: scl_out[0], sda_out[1], chip_select_n[2], busy_res[3],
    // read_data[11:4], ack_missing[12], zero pad.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [0:0]  m_tuser,
    output logic [iebam_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // Configuration registers; they must be written only while the bus is idle, which the block does not enforce.
    iebam_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_wait_limit    <= iebam_pkg::ACK_WAIT_LIMIT_RST;
            cfg_reg.write_cycle_ticks <= iebam_pkg::WRITE_CYCLE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                iebam_pkg::REG_ACK_WAIT_LIMIT:    cfg_reg.ack_wait_limit <= cfg_data[7:0];
                iebam_pkg::REG_WRITE_CYCLE_TICKS: cfg_reg.write_cycle_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register. It refills in the same cycle that its tick moves on.
    logic             in_valid_reg;
    iebam_pkg::item_t in_item_reg;
    iebam_pkg::item_t in_item;
    logic             q_ready;
    logic             advance;

    assign in_item.cmd_valid  = s_tuser[0];
    assign in_item.func       = s_tuser[1];
    assign in_item.word_addr  = s_tdata[7:0];
    assign in_item.page_sel   = s_tdata[10:8];
    assign in_item.write_data = s_tdata[18:11];
    assign in_item.sda_in     = s_tdata[19];

    assign advance  = in_valid_reg && q_ready;
    assign s_tready = !in_valid_reg || q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_item_reg <= in_item;
    end

    // The sequencer steps exactly once per tick transaction that reaches it.
    iebam_pkg::result_t step_result;

    iebam_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (step_result)
    );

    iebam_pkg::result_t out_result;

    iebam_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (advance),
        .push_data  (step_result),
        .push_ready (q_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_result)
    );

    assign m_tuser[0] = out_result.read_valid;
    assign m_tdata    = {3'd0, out_result.ack_missing, out_result.read_data,
                         out_result.busy_res, out_result.chip_select_n,
                         out_result.sda_out, out_result.scl_out};

endmodule

[tb/eeprom_bus_checker.sv]
`timescale 1ns / 1ps

module eeprom_bus_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [15:0]                       cfg_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [1:0]                        s_tuser,
    input  logic [iebam_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [0:0]                        m_tuser,
    input  logic [iebam_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                                fail_count,
    output int                                pending
);

    // Shadow copy of the configuration registers.
    logic [7:0]                    ack_limit;
    logic [15:0]                   wcyc_len;

    // Shadow copy of the bus sequencer.
    logic [iebam_pkg::PHASE_W-1:0] seq_phase;
    logic [3:0]                    half_cnt;
    logic [7:0]                    shifter;
    logic [15:0]                   ack_wait;
    logic [7:0]                    addr_q;
    logic [2:0]                    page_q;
    logic [7:0]                    data_q;
    logic                          reading;
    logic                          nack_flag;

    iebam_pkg::result_t            expected_lines[$];
    int                            mismatch_total;

    // One half of a bit cell: SCL low with the bit set up, or SCL high.
    task automatic shift_out_half(output logic scl, output logic sda,
                                  input logic [iebam_pkg::PHASE_W-1:0] ack_phase);
        begin
            sda = shifter[7];
            scl = half_cnt[0];
            if (half_cnt[0])
                shifter = {shifter[6:0], 1'b0};
            if (half_cnt == iebam_pkg::LAST_HALF_BIT)
            begin
                seq_phase = ack_phase;
                half_cnt  = '0;
                ack_wait  = '0;
            end
            else
            begin
                half_cnt = half_cnt + 4'd1;
            end
        end
    endtask

    // Acknowledge slot; done is set on the closing SCL-low tick.
    task automatic ack_half(input logic sd, output logic scl, output logic sda,
                            output logic done);
        begin
            sda  = 1'b1;
            done = 1'b0;
            if (half_cnt == 4'd0)
            begin
                scl = 1'b1;
                if (!sd)
                begin
                    half_cnt = 4'd1;
                end
                else if (ack_wait >= {8'd0, ack_limit})
                begin
                    nack_flag = 1'b1;
                    half_cnt  = 4'd1;
                end
                else
                begin
                    ack_wait = ack_wait + 16'd1;
                end
            end
            else
            begin
                scl      = 1'b0;
                half_cnt = '0;
                done     = 1'b1;
            end
        end
    endtask

    task automatic step_bus_sequencer(input iebam_pkg::item_t tick,
                                      output iebam_pkg::result_t line);
        logic       scl;
        logic       sda;
        logic       busy;
        logic       rv;
        logic       done;
        logic       active;
        logic [7:0] rd;
        begin
            scl    = 1'b1;
            sda    = 1'b1;
            busy   = 1'b1;
            rv     = 1'b0;
            rd     = 8'd0;
            done   = 1'b0;
            active = (seq_phase != iebam_pkg::PH_IDLE);
            case (seq_phase)
                iebam_pkg::PH_IDLE:
                begin
                    busy = 1'b0;
                    if (tick.cmd_valid)
                    begin
                        addr_q    = tick.word_addr;
                        page_q    = tick.page_sel;
                        data_q    = tick.write_data;
                        reading   = tick.func;
                        nack_flag = 1'b0;
                        half_cnt  = '0;
                        ack_wait  = '0;
                        shifter   = {iebam_pkg::CTRL_BYTE_BASE[7:4], tick.page_sel, 1'b0};
                        seq_phase = iebam_pkg::PH_ST_A;
                        busy      = 1'b1;
                        active    = 1'b1;
                    end
                end
                iebam_pkg::PH_ST_A: seq_phase = iebam_pkg::PH_ST_B;
                iebam_pkg::PH_ST_B:
                begin
                    sda       = 1'b0;
                    half_cnt  = '0;
                    seq_phase = iebam_pkg::PH_TX_C;
                end
                iebam_pkg::PH_TX_C: shift_out_half(scl, sda, iebam_pkg::PH_AK_C);
                iebam_pkg::PH_AK_C:
                begin
                    ack_half(tick.sda_in, scl, sda, done);
                    if (done)
                    begin
                        shifter   = addr_q;
                        seq_phase = iebam_pkg::PH_TX_A;
                    end
                end
                iebam_pkg::PH_TX_A: shift_out_half(scl, sda, iebam_pkg::PH_AK_A);
                iebam_pkg::PH_AK_A:
                begin
                    ack_half(tick.sda_in, scl, sda, done);
                    if (done)
                    begin
                        if (reading)
                        begin
                            seq_phase = iebam_pkg::PH_RS_A;
                        end
                        else
                        begin
                            shifter   = data_q;
                            seq_phase = iebam_pkg::PH_TX_D;
                        end
                    end
                end
                iebam_pkg::PH_TX_D: shift_out_half(scl, sda, iebam_pkg::PH_AK_D);
                iebam_pkg::PH_AK_D:
                begin
                    ack_half(tick.sda_in, scl, sda, done);
                    if (done)
                        seq_phase = iebam_pkg::PH_SP_A;
                end
                iebam_pkg::PH_RS_A:
                begin
                    scl       = 1'b0;
                    seq_phase = iebam_pkg::PH_RS_B;
                end
                iebam_pkg::PH_RS_B: seq_phase = iebam_pkg::PH_RS_C;
                iebam_pkg::PH_RS_C:
                begin
                    sda       = 1'b0;
                    shifter   = {iebam_pkg::CTRL_BYTE_BASE[7:4], page_q, 1'b1};
                    half_cnt  = '0;
                    seq_phase = iebam_pkg::PH_TX_R;
                end
                iebam_pkg::PH_TX_R: shift_out_half(scl, sda, iebam_pkg::PH_AK_R);
                iebam_pkg::PH_AK_R:
                begin
                    ack_half(tick.sda_in, scl, sda, done);
                    if (done)
                    begin
                        shifter   = 8'd0;
                        seq_phase = iebam_pkg::PH_RX;
                    end
                end
                iebam_pkg::PH_RX:
                begin
                    scl = half_cnt[0];
                    if (half_cnt[0])
                        shifter = {shifter[6:0], tick.sda_in};
                    if (half_cnt == iebam_pkg::LAST_HALF_BIT)
                    begin
                        half_cnt  = '0;
                        seq_phase = iebam_pkg::PH_NACK;
                    end
                    else
                    begin
                        half_cnt = half_cnt + 4'd1;
                    end
                end
                iebam_pkg::PH_NACK:
                begin
                    scl = half_cnt[0];
                    if (half_cnt == 4'd0)
                    begin
                        half_cnt = 4'd1;
                    end
                    else
                    begin
                        half_cnt  = '0;
                        seq_phase = iebam_pkg::PH_SP_A;
                    end
                end
                iebam_pkg::PH_SP_A:
                begin
                    scl       = 1'b0;
                    sda       = 1'b0;
                    seq_phase = iebam_pkg::PH_SP_B;
                end
                iebam_pkg::PH_SP_B:
                begin
                    sda       = 1'b0;
                    seq_phase = iebam_pkg::PH_SP_C;
                end
                iebam_pkg::PH_SP_C:
                begin
                    if (reading)
                    begin
                        rv        = 1'b1;
                        rd        = shifter;
                        seq_phase = iebam_pkg::PH_IDLE;
                    end
                    else
                    begin
                        ack_wait  = '0;
                        seq_phase = iebam_pkg::PH_WCYC;
                    end
                end
                iebam_pkg::PH_WCYC:
                begin
                    if (ack_wait >= wcyc_len)
                        seq_phase = iebam_pkg::PH_IDLE;
                    else
                        ack_wait = ack_wait + 16'd1;
                end
                default:
                begin
                    busy      = 1'b0;
                    active    = 1'b0;
                    seq_phase = iebam_pkg::PH_IDLE;
                end
            endcase
            line.scl_out       = scl;
            line.sda_out       = sda;
            line.chip_select_n = !(active && !reading);
            line.busy_res      = busy;
            line.read_valid    = rv;
            line.read_data     = rd;
            line.ack_missing   = nack_flag;
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        begin
            if (want != got)
            begin
                mismatch_total++;
                if (mismatch_total <= 10)
                    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        iebam_pkg::item_t   tick;
        iebam_pkg::result_t line;
        iebam_pkg::result_t got;
        if (!rst_n)
        begin
            ack_limit  = iebam_pkg::ACK_WAIT_LIMIT_RST;
            wcyc_len   = iebam_pkg::WRITE_CYCLE_TICKS_RST;
            seq_phase  = iebam_pkg::PH_IDLE;
            half_cnt   = '0;
            shifter    = '0;
            ack_wait   = '0;
            addr_q     = '0;
            page_q     = '0;
            data_q     = '0;
            reading    = 1'b0;
            nack_flag  = 1'b0;
            expected_lines.delete();
            mismatch_total = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == iebam_pkg::REG_ACK_WAIT_LIMIT)
                    ack_limit = cfg_data[7:0];
                else
                    wcyc_len = cfg_data;
            end

            if (s_tvalid && s_tready)
            begin
                tick.cmd_valid  = s_tuser[0];
                tick.func       = s_tuser[1];
                tick.word_addr  = s_tdata[7:0];
                tick.page_sel   = s_tdata[10:8];
                tick.write_data = s_tdata[18:11];
                tick.sda_in     = s_tdata[19];
                step_bus_sequencer(tick, line);
                expected_lines.push_back(line);
            end

            if (m_tvalid && m_tready)
            begin
                got.scl_out       = m_tdata[0];
                got.sda_out       = m_tdata[1];
                got.chip_select_n = m_tdata[2];
                got.busy_res      = m_tdata[3];
                got.read_data     = m_tdata[11:4];
                got.ack_missing   = m_tdata[12];
                got.read_valid    = m_tuser[0];
                if (expected_lines.size() == 0)
                begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("%0t: result with nothing expected, tdata %h tuser %b",
                                 $time, m_tdata, m_tuser);
                end
                else
                begin
                    line = expected_lines.pop_front();
                    compare_field("scl_out", line.scl_out, got.scl_out);
                    compare_field("sda_out", line.sda_out, got.sda_out);
                    compare_field("chip_select_n", line.chip_select_n, got.chip_select_n);
                    compare_field("busy_res", line.busy_res, got.busy_res);
                    compare_field("read_valid", line.read_valid, got.read_valid);
                    compare_field("read_data", line.read_data, got.read_data);
                    compare_field("ack_missing", line.ack_missing, got.ack_missing);
                end
            end

            pending    <= expected_lines.size();
            fail_count <= mismatch_total;
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

    // How the stimulus drives the sampled SDA level. Noise flips it at random,
    // the acking mode mostly holds it low so that the slave acknowledges at
    // once, and the released mode leaves it high so that every acknowledge
    // wait runs into its limit and read data comes back as all ones.
    typedef enum int {SDA_NOISE, SDA_ACKING, SDA_RELEASED} sda_mode_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic                              cfg_addr;
    logic [15:0]                       cfg_data;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [1:0]                        s_tuser;    // cmd_valid, func
    // word_addr, page_sel, write_data, sda_in, zero pad
    logic [iebam_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [0:0]                        m_tuser;    // read_valid
    // scl, sda, cs_n, busy, read_data, ack_missing
    logic [iebam_pkg::OUT_TDATA_W-1:0] m_tdata;

    int                                fail_count;
    int                                pending;

    // Sender burst bookkeeping and the configuration currently programmed.
    int                                burst_left;
    logic [7:0]                        cur_limit;
    logic [15:0]                       cur_wcyc;

    i2c_eeprom_byte_access_master u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    // The checker sees both channels and the configuration port, keeps its own
    // model of the sequencer and reports the number of failures it found.
    eeprom_bus_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit on the run. Even with the worst sender gaps and receiver
    // stalls a correct run stays well below this.
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result receiver. It follows a stall pattern that it redraws again and
    // again: sometimes always ready, sometimes ready at random, sometimes dense. It also
    // refuses results in holds long enough for the internal pipeline to fill up
    // and push back on the tick input.
    initial
    begin
        int          cyc;
        int          hold_left;
        int          pmode;
        logic [15:0] pat;
        m_tready  = 1'b0;
        cyc       = 0;
        hold_left = 0;
        pat       = 16'hFFFF;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 64 == 0)
            begin
                pmode = $urandom_range(0, 3);
                if (pmode == 0)
                    pat = 16'hFFFF;
                else if (pmode == 1)
                    pat = 16'($urandom);
                else
                    pat = 16'($urandom | $urandom);
            end
            if (cyc % 2000 == 500)
                hold_left = 150;
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= pat[0];
                pat = {pat[0], pat[15:1]};
            end
        end
    end

    function automatic logic sda_level(input sda_mode_t mode);
        begin
            if (mode == SDA_NOISE)
                sda_level = 1'($urandom_range(0, 1));
            else if (mode == SDA_ACKING)
                sda_level = ($urandom_range(0, 7) == 0);
            else
                sda_level = 1'b1;
        end
    endfunction

    // Offers one tick and returns right after the edge at which the
    // transaction is accepted. The sender works in bursts of random length;
    // between bursts it sometimes drops valid.
    task automatic send_tick(input logic cmd, input logic func, input logic [7:0] addr,
                             input logic [2:0] page, input logic [7:0] data,
                             input logic sda);
        int gap;
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 48);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
            burst_left--;
            @(negedge clk);
            s_tvalid <= 1'b1;
            s_tuser  <= {func, cmd};
            s_tdata  <= {4'd0, sda, data, page, addr};
            @(posedge clk);
            while (!s_tready) @(posedge clk);
        end
    endtask

    task automatic send_noise_tick(input logic cmd, input sda_mode_t mode);
        begin
            send_tick(cmd, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      sda_level(mode));
        end
    endtask

    // Enough ticks without a command for any bus access under the current
    // settings to run to its end. The write cycle wait only counts when a
    // write may still be running.
    task automatic let_finish(input sda_mode_t mode, input logic with_wcyc);
        int bound;
        begin
            bound = 3 * (int'(cur_limit) + 2) + 80;
            if (with_wcyc)
                bound = bound + int'(cur_wcyc);
            repeat (bound) send_noise_tick(1'b0, mode);
        end
    endtask

    // Stops offering ticks and waits until every expected result is back.
    task automatic settle();
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
            repeat (8) @(posedge clk);
        end
    endtask

    task automatic write_register(input logic idx, input logic [15:0] value);
        begin
            @(negedge clk);
            cfg_we   <= 1'b1;
            cfg_addr <= idx;
            cfg_data <= value;
            @(negedge clk);
            cfg_we   <= 1'b0;
        end
    endtask

    task automatic set_timing(input logic [7:0] limit, input logic [15:0] wcyc);
        begin
            settle();
            write_register(iebam_pkg::REG_ACK_WAIT_LIMIT, {8'd0, limit});
            write_register(iebam_pkg::REG_WRITE_CYCLE_TICKS, wcyc);
            cur_limit = limit;
            cur_wcyc  = wcyc;
        end
    endtask

    // One bus access. The twenty ticks right after the command also carry
    // commands, which the block has to ignore since it is already busy.
    task automatic run_command(input logic func, input logic [7:0] addr,
                               input logic [2:0] page, input logic [7:0] data,
                               input sda_mode_t mode);
        begin
            send_tick(1'b1, func, addr, page, data, sda_level(mode));
            repeat (20) send_noise_tick(1'b1, mode);
            let_finish(mode, !func);
        end
    endtask

    initial
    begin
        int        chunk;
        int        n;
        int        r;
        sda_mode_t mode;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = iebam_pkg::REG_ACK_WAIT_LIMIT;
        cfg_data   = 16'd0;
        s_tvalid   = 1'b0;
        s_tuser    = 2'b00;
        s_tdata    = '0;
        burst_left = 0;
        cur_limit  = iebam_pkg::ACK_WAIT_LIMIT_RST;
        cur_wcyc   = iebam_pkg::WRITE_CYCLE_TICKS_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, first with the reset settings. A read of block 0 at
        // address 0 with SDA left high makes every acknowledge time out at the
        // default limit and reads all ones.
        run_command(1'b1, 8'h00, 3'd0, 8'h00, SDA_RELEASED);

        // Zero acknowledge limit samples SDA once; zero write cycle lasts one tick.
        // A write with every field at its maximum is mostly acknowledged at once.
        set_timing(8'd0, 16'd0);
        run_command(1'b0, 8'hFF, 3'd7, 8'hFF, SDA_ACKING);
        run_command(1'b0, 8'h00, 3'd0, 8'h00, SDA_RELEASED);
        run_command(1'b1, 8'hAA, 3'd5, 8'h55, SDA_NOISE);

        // Random part. Each chunk gets fresh short settings so that many bus
        // accesses fit in. Commands come often enough that the block rarely
        // sits idle for long.
        for (chunk = 0; chunk < 3; chunk++)
        begin
            set_timing(8'($urandom_range(0, 15)), 16'($urandom_range(0, 60)));
            mode = SDA_NOISE;
            for (n = 0; n < 170; n++)
            begin
                if (n % 32 == 0)
                begin
                    r = $urandom_range(0, 9);
                    if (r < 5)
                        mode = SDA_NOISE;
                    else if (r < 8)
                        mode = SDA_ACKING;
                    else
                        mode = SDA_RELEASED;
                end
                send_noise_tick($urandom_range(0, 99) < 30, mode);
            end
            let_finish(SDA_NOISE, 1'b1);
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
